[rtl/id_free_list_allocator_core_macros.svh]
// assertion macros for the id free-list allocator core
// used by id_free_list_allocator_core.sv; expects clk_i and rst_ni in scope
`ifndef ID_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define ID_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define IFLA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ifla_pkg.sv]
// shared types and constants for the id free-list allocator
// no dependencies
`default_nettype none

package ifla_pkg;

  localparam int NumIdsDefault = 1024;
  localparam int IdW           = 10;

  typedef enum logic [1:0] {
    ModeAlloc = 2'd0,
    ModeFree  = 2'd1,
    ModeQuery = 2'd2,
    ModeSet   = 2'd3
  } ifla_mode_e;

  typedef enum logic [1:0] {
    ErrOk    = 2'd0,
    ErrEmpty = 2'd1,
    ErrFull  = 2'd2
  } ifla_err_e;

endpackage

`default_nettype wire

[rtl/id_free_list_allocator_core.sv]
// id free-list allocator: stack of free ids plus one enable bit per id
// depends on ifla_pkg and id_free_list_allocator_core_macros.svh
//
// usage:
//   input channel (in_valid_i/in_ready_o) carries one request item: mode_i,
//   entity_id_i, enable_value_i. modes are allocate, free, query enable and
//   set enable. output channel (out_valid_o/out_ready_i) returns exactly one
//   item per request: result_id_o, enabled_o, error_code_o.
//   latency: the result is offered on the cycle after the request is taken.
//   throughput: one item per cycle; the stack pointer moves at accept time,
//   so back-to-back allocate/free need no bubble. the enable memory is
//   written when a result leaves and a same-address read is forwarded.
//   stall: while a result waits, in_ready_o follows out_ready_i, so a new
//   item enters in the same cycle the waiting result is taken.
//   reset: after rst_ni rises a clearing pass of NUM_IDS cycles loads
//   stack entry i with id i and clears every enable bit; in_ready_o stays
//   low during the pass. the stack pointer starts at NUM_IDS (all free).
//   free does not check that the id was allocated; errors leave state as is.
`default_nettype none

`include "id_free_list_allocator_core_macros.svh"

module id_free_list_allocator_core #(
  parameter int NUM_IDS = ifla_pkg::NumIdsDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [1:0]               mode_i,
  input  wire logic [ifla_pkg::IdW-1:0] entity_id_i,
  input  wire logic                     enable_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [ifla_pkg::IdW-1:0]      result_id_o,
  output logic                          enabled_o,
  output logic [1:0]                    error_code_o
);

  localparam int IdWidth = ifla_pkg::IdW;
  localparam int IdxW    = $clog2(NUM_IDS);
  localparam int PtrW    = $clog2(NUM_IDS + 1);

  typedef enum logic {
    StClear,
    StRun
  } state_e;

  // request held in the result stage
  typedef struct packed {
    ifla_pkg::ifla_mode_e mode;
    logic [IdWidth-1:0]   id;
    logic                 val;
    ifla_pkg::ifla_err_e  err;
    logic                 id_ok;
    logic                 hit;
    logic                 hit_val;
  } s1_t;

  state_e            state_q;
  logic [IdxW-1:0]   clr_cnt_q;
  logic [PtrW-1:0]   top_q, top_d;
  logic              s1_valid_q;
  s1_t               s1_q, s1_d;

  // memories
  logic [IdxW-1:0]   stack_mem [NUM_IDS];
  logic              en_mem    [NUM_IDS];
  logic [IdxW-1:0]   stk_rdata_q;
  logic              en_rdata_q;

  logic              stk_we, stk_re;
  logic [IdxW-1:0]   stk_waddr, stk_wdata, stk_raddr;
  logic              en_we;
  logic [IdxW-1:0]   en_waddr;
  logic              en_wdata;

  // front side
  ifla_pkg::ifla_mode_e in_mode;
  logic              acc;
  logic              id_ok;
  logic              stack_empty, stack_full;
  logic              push, pop;
  ifla_pkg::ifla_err_e in_err;

  // result side
  logic              out_fire;
  logic              en_cur;
  logic              s1_we;
  logic [IdxW-1:0]   s1_waddr;
  logic              s1_wdata;
  logic [IdWidth-1:0] res_id;
  logic              res_en;

  assign in_mode     = ifla_pkg::ifla_mode_e'(mode_i);
  assign in_ready_o  = (state_q == StRun) && (!s1_valid_q || out_ready_i);
  assign acc         = in_valid_i && in_ready_o;
  assign id_ok       = (32'(entity_id_i) < 32'(NUM_IDS));
  assign stack_empty = (top_q == '0);
  assign stack_full  = (top_q == PtrW'(NUM_IDS));
  assign out_fire    = s1_valid_q && out_ready_i;

  // error code and stack moves decided from the mode, the pointer and the id range
  always_comb begin
    in_err = ifla_pkg::ErrOk;
    push   = 1'b0;
    pop    = 1'b0;
    case (in_mode)
      ifla_pkg::ModeAlloc: begin
        if (stack_empty) begin
          in_err = ifla_pkg::ErrEmpty;
        end else begin
          pop = 1'b1;
        end
      end
      ifla_pkg::ModeFree: begin
        if (id_ok) begin
          if (stack_full) begin
            in_err = ifla_pkg::ErrFull;
          end else begin
            push = 1'b1;
          end
        end
      end
      default: begin
        in_err = ifla_pkg::ErrOk;
      end
    endcase
  end

  always_comb begin
    top_d = top_q;
    if (acc && pop) begin
      top_d = top_q - PtrW'(1);
    end else if (acc && push) begin
      top_d = top_q + PtrW'(1);
    end
  end

  // stack port: clearing pass loads identity, else free pushes at accept
  always_comb begin
    if (state_q == StClear) begin
      stk_we    = 1'b1;
      stk_waddr = clr_cnt_q;
      stk_wdata = clr_cnt_q;
    end else begin
      stk_we    = acc && push;
      stk_waddr = IdxW'(top_q);
      stk_wdata = IdxW'(entity_id_i);
    end
  end

  assign stk_re    = acc && pop;
  assign stk_raddr = IdxW'(top_q - PtrW'(1));

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stack_mem[stk_raddr];
    end
  end

  // result stage: enable bit with forwarding from the item that just left
  assign en_cur = s1_q.hit ? s1_q.hit_val : en_rdata_q;

  always_comb begin
    res_id   = s1_q.id;
    res_en   = en_cur;
    s1_we    = 1'b0;
    s1_waddr = IdxW'(s1_q.id);
    s1_wdata = 1'b0;
    case (s1_q.mode)
      ifla_pkg::ModeAlloc: begin
        if (s1_q.err == ifla_pkg::ErrOk) begin
          res_id   = IdWidth'(stk_rdata_q);
          res_en   = 1'b1;
          s1_we    = 1'b1;
          s1_waddr = stk_rdata_q;
          s1_wdata = 1'b1;
        end else begin
          res_id = '0;
          res_en = 1'b0;
        end
      end
      ifla_pkg::ModeFree: begin
        if (!s1_q.id_ok) begin
          res_en = 1'b0;
        end else if (s1_q.err == ifla_pkg::ErrOk) begin
          res_en = 1'b0;
          s1_we  = 1'b1;
        end
      end
      ifla_pkg::ModeQuery: begin
        if (!s1_q.id_ok) begin
          res_en = 1'b0;
        end
      end
      ifla_pkg::ModeSet: begin
        if (!s1_q.id_ok) begin
          res_en = 1'b0;
        end else begin
          res_en   = s1_q.val;
          s1_we    = 1'b1;
          s1_wdata = s1_q.val;
        end
      end
      default: begin
        res_en = en_cur;
      end
    endcase
  end

  // enable port: clearing pass or the write of the departing item
  always_comb begin
    if (state_q == StClear) begin
      en_we    = 1'b1;
      en_waddr = clr_cnt_q;
      en_wdata = 1'b0;
    end else begin
      en_we    = out_fire && s1_we;
      en_waddr = s1_waddr;
      en_wdata = s1_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_we) begin
      en_mem[en_waddr] <= en_wdata;
    end
    if (acc) begin
      en_rdata_q <= en_mem[IdxW'(entity_id_i)];
    end
  end

  always_comb begin
    s1_d.mode    = in_mode;
    s1_d.id      = entity_id_i;
    s1_d.val     = enable_value_i;
    s1_d.err     = in_err;
    s1_d.id_ok   = id_ok;
    // memory read sees the old bit when the same entry is written this edge
    s1_d.hit     = en_we && (en_waddr == IdxW'(entity_id_i));
    s1_d.hit_val = en_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= s1_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_cnt_q <= '0;
    end else begin
      case (state_q)
        StClear: begin
          if (clr_cnt_q == IdxW'(NUM_IDS - 1)) begin
            state_q <= StRun;
          end else begin
            clr_cnt_q <= clr_cnt_q + IdxW'(1);
          end
        end
        StRun: begin
          state_q <= StRun;
        end
        default: begin
          state_q <= StClear;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q      <= PtrW'(NUM_IDS);
      s1_valid_q <= 1'b0;
    end else begin
      top_q <= top_d;
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (out_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = s1_valid_q;
  assign result_id_o  = res_id;
  assign enabled_o    = res_en;
  assign error_code_o = s1_q.err;

  // checks
  `IFLA_ASSERT_IMPL(a_top_in_range, 1'b1, top_q <= PtrW'(NUM_IDS), "stack pointer above capacity")
  `IFLA_ASSERT_IMPL(a_no_accept_in_clear, state_q == StClear, !in_ready_o, "item taken during clear")
  `IFLA_ASSERT_NEXT(a_pop_moves_top, acc && pop, top_q == $past(top_q) - PtrW'(1), "pop lost")
  `IFLA_ASSERT_NEXT(a_push_moves_top, acc && push, top_q == $past(top_q) + PtrW'(1), "push lost")

endmodule

`default_nettype wire

[sim/id_free_list_allocator_checker.sv]
// scoreboard for the id free-list allocator: watches both channels, predicts, compares
// depends on ifla_pkg
`default_nettype none

module id_free_list_allocator_checker
  import ifla_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_ready_i,
  input  wire logic [1:0]     mode_i,
  input  wire logic [IdW-1:0] entity_id_i,
  input  wire logic           enable_value_i,
  input  wire logic           out_valid_i,
  input  wire logic           out_ready_i,
  input  wire logic [IdW-1:0] result_id_i,
  input  wire logic           enabled_i,
  input  wire logic [1:0]     error_code_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumIds = NumIdsDefault;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic           en;
    logic [1:0]     err;
  } grant_t;

  // shadow allocator state
  logic [IdW-1:0] free_ids [NumIds];
  logic           id_enable [NumIds];
  int             free_top;

  grant_t due_results [$];

  // applies one request to the shadow state and returns the item it should produce
  function automatic grant_t serve_request(ifla_mode_e m, logic [IdW-1:0] id, logic v);
    grant_t g;
    logic [IdW-1:0] got;
    g.id  = id;
    g.en  = 1'b0;
    g.err = ErrOk;
    if (m == ModeAlloc) begin
      if (free_top == 0) begin
        g.id  = '0;
        g.err = ErrEmpty;
      end else begin
        free_top--;
        got = free_ids[free_top];
        if (int'(got) < NumIds) id_enable[got] = 1'b1;
        g.id = got;
        g.en = 1'b1;
      end
      return g;
    end
    // ids outside the pool are echoed untouched
    if (int'(id) >= NumIds) return g;
    case (m)
      ModeFree: begin
        if (free_top >= NumIds) begin
          g.en  = id_enable[id];
          g.err = ErrFull;
        end else begin
          free_ids[free_top] = id;
          free_top++;
          id_enable[id] = 1'b0;
        end
      end
      ModeSet: begin
        id_enable[id] = v;
        g.en = v;
      end
      default: g.en = id_enable[id];
    endcase
    return g;
  endfunction

  task automatic note_failure(string what, grant_t want, grant_t seen);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("%0t checker: %s want id=%0d en=%0b err=%0d got id=%0d en=%0b err=%0d",
               $realtime, what, want.id, want.en, want.err, seen.id, seen.en, seen.err);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_t want;
    grant_t seen;
    if (!rst_ni) begin
      for (int i = 0; i < NumIds; i++) begin
        free_ids[i]  = IdW'(i);
        id_enable[i] = 1'b0;
      end
      free_top = NumIds;
      due_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // result side first, so an item leaving and one entering in the same cycle stay ordered
      if (out_valid_i && out_ready_i) begin
        seen = {result_id_i, enabled_i, error_code_i};
        if (due_results.size() == 0) begin
          note_failure("unexpected item", '0, seen);
        end else begin
          want = due_results.pop_front();
          if (seen !== want) note_failure("mismatch", want, seen);
        end
      end
      if (in_valid_i && in_ready_i)
        due_results.push_back(serve_request(ifla_mode_e'(mode_i), entity_id_i,
                                            enable_value_i));
      pending_o = due_results.size();
    end
  end

endmodule

`default_nettype wire

[sim/testbench.sv]
// top of the id free-list allocator bench: clock, reset, request stimulus, verdict
// depends on ifla_pkg, id_free_list_allocator_core and id_free_list_allocator_checker
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ifla_pkg::*;

  localparam int NumIds     = NumIdsDefault;
  localparam int RandItems  = 1680;
  localparam int IdlePct    = 19;
  localparam int HoldCycles = 64;

  logic           clk          = 1'b0;
  logic           rst_n        = 1'b0;
  logic           in_valid     = 1'b0;
  logic           in_ready;
  ifla_mode_e     mode         = ModeAlloc;
  logic [IdW-1:0] entity_id    = '0;
  logic           enable_value = 1'b0;
  logic           out_valid;
  logic           out_ready    = 1'b0;
  logic [IdW-1:0] result_id;
  logic           enabled;
  logic [1:0]     error_code;

  int fail_count;
  int pending;

  // stimulus-side view of the stack depth, used only to steer the mix of modes
  int pool_level = NumIds;
  // no idling on either side while set
  bit steady_run = 1'b0;
  // asks the result side for one long hold-off
  bit hold_req   = 1'b0;

  always #5ns clk = ~clk;

  id_free_list_allocator_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .entity_id_i    (entity_id),
    .enable_value_i (enable_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_id_o    (result_id),
    .enabled_o      (enabled),
    .error_code_o   (error_code)
  );

  id_free_list_allocator_checker scoreboard (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .mode_i         (mode),
    .entity_id_i    (entity_id),
    .enable_value_i (enable_value),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_id_i    (result_id),
    .enabled_i      (enabled),
    .error_code_i   (error_code),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // one request item: called and returns at a falling edge, holds valid and payload
  // until the item is taken at a rising edge
  task automatic offer_item(ifla_mode_e m, logic [IdW-1:0] id, logic v);
    while (!steady_run && $urandom_range(99) < IdlePct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    mode         = m;
    entity_id    = id;
    enable_value = v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    // track depth the same way the pool moves: pop on allocate, push on free
    if (m == ModeAlloc && pool_level > 0) pool_level--;
    if (m == ModeFree && pool_level < NumIds) pool_level++;
  endtask

  // result side: random back-pressure, plus one long hold-off on request
  initial begin : result_side
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // block fills up and must stall its input while this lasts
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready = steady_run || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin : stimulus
    int r;
    int empty_hits;
    int waited;
    bit drained;
    ifla_mode_e m;
    logic [IdW-1:0] id;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    // the block runs its clearing pass now; offer_item simply waits on in_ready

    // directed: pool starts full, so a free is refused
    offer_item(ModeFree, 10'd0, 1'b0);
    offer_item(ModeFree, 10'd1023, 1'b1);
    offer_item(ModeQuery, 10'd0, 1'b1);
    offer_item(ModeQuery, 10'd1023, 1'b0);
    offer_item(ModeSet, 10'd1023, 1'b1);
    offer_item(ModeQuery, 10'd1023, 1'b0);
    // allocate ignores the id and value fields
    offer_item(ModeAlloc, 10'd1023, 1'b1);
    offer_item(ModeAlloc, 10'd0, 1'b0);
    offer_item(ModeQuery, 10'd1022, 1'b1);
    offer_item(ModeSet, 10'd1022, 1'b0);
    offer_item(ModeFree, 10'd1022, 1'b1);
    // double free goes through unchecked
    offer_item(ModeFree, 10'd1022, 1'b0);
    offer_item(ModeFree, 10'd5, 1'b1);
    // the doubly freed id comes out twice
    offer_item(ModeAlloc, 10'd512, 1'b1);
    offer_item(ModeAlloc, 10'd0, 1'b0);
    offer_item(ModeAlloc, 10'd0, 1'b0);
    offer_item(ModeSet, 10'd0, 1'b1);
    offer_item(ModeSet, 10'd0, 1'b0);
    offer_item(ModeSet, 10'd1023, 1'b0);
    offer_item(ModeQuery, 10'd1023, 1'b1);
    offer_item(ModeFree, 10'd1021, 1'b0);
    offer_item(ModeQuery, 10'd1021, 1'b0);
    offer_item(ModeAlloc, 10'd0, 1'b1);
    offer_item(ModeFree, 10'd1023, 1'b1);

    // random: first drain the pool with mostly allocates and keep hitting the
    // empty case for a while, then refill with mostly frees
    empty_hits = 0;
    drained    = 1'b0;
    for (int n = 0; n < RandItems; n++) begin
      steady_run = (n >= 300 && n < 520);
      if (n == 700) hold_req = 1'b1;

      r = $urandom_range(99);
      if (!drained) begin
        if (r < 88)      m = ModeAlloc;
        else if (r < 92) m = ModeFree;
        else if (r < 96) m = ModeQuery;
        else             m = ModeSet;
      end else begin
        if (r < 50)      m = ModeFree;
        else if (r < 65) m = ModeAlloc;
        else if (r < 82) m = ModeQuery;
        else             m = ModeSet;
      end
      if (m == ModeAlloc && pool_level == 0) empty_hits++;
      if (empty_hits >= 12) drained = 1'b1;

      // ids: some extremes, a small hot range for repeated frees, the rest anywhere
      r = $urandom_range(99);
      if (r < 10)      id = $urandom_range(1) ? '1 : '0;
      else if (r < 35) id = IdW'($urandom_range(7));
      else             id = IdW'($urandom_range(NumIds - 1));

      offer_item(m, id, 1'($urandom_range(1)));
    end
    steady_run = 1'b0;
    in_valid   = 1'b0;

    // let every outstanding item come back, bounded
    for (waited = 0; pending != 0 && waited < 5000; waited++) @(negedge clk);
    repeat (10) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
